@@ hdl/lftc_pkg.sv @@
// ----------------------------------------------------------------------------
// lftc_pkg
// Shared types and bit positions for the two-floor lift controller.
// ----------------------------------------------------------------------------
package lftc_pkg;

  localparam int unsigned IO_W    = 6;
  localparam int unsigned TIMER_W = 10;

  // Request latch bits (raw inputs are active low, latches active high)
  localparam int unsigned B_CALL0 = 0;
  localparam int unsigned B_CALL1 = 1;
  localparam int unsigned B_OK0   = 2;
  localparam int unsigned B_OK1   = 3;
  localparam int unsigned B_CLOSE = 4;
  localparam int unsigned B_OPEN  = 5;

  // Drive bits
  localparam int unsigned D_LAMP0  = 0;
  localparam int unsigned D_LAMP1  = 1;
  localparam int unsigned D_DOPEN  = 2;
  localparam int unsigned D_DCLOSE = 3;
  localparam int unsigned D_UP     = 4;
  localparam int unsigned D_DOWN   = 5;

  localparam logic [TIMER_W-1:0] TIMER_MAX     = '1;
  localparam logic [TIMER_W-1:0] OPEN_RESET    = TIMER_W'(50);
  localparam logic [TIMER_W-1:0] TRAVEL_RESET  = TIMER_W'(50);
  localparam logic [IO_W-1:0]    LATCH_RESET   = IO_W'(1) << B_OK0;

  // Configuration register indexes
  localparam logic CFG_OPEN_POLLS   = 1'b0;
  localparam logic CFG_TRAVEL_POLLS = 1'b1;

  typedef enum logic [2:0] {
    PH_CLOSED0 = 3'd0,
    PH_CLOSED1 = 3'd1,
    PH_OPEN0   = 3'd2,
    PH_OPEN1   = 3'd3,
    PH_WAIT0   = 3'd4,
    PH_WAIT1   = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [IO_W-1:0]    latches;
    logic [TIMER_W-1:0] door_timer;
    logic [TIMER_W-1:0] travel_timer;
    logic [IO_W-1:0]    drive;
  } lift_state_t;

  typedef struct packed {
    logic [IO_W-1:0] drive_bits;
    logic [2:0]      state_code;
    logic            moving;
  } lift_result_t;

endpackage

@@ hdl/two_floor_lift_controller_core.sv @@
// ----------------------------------------------------------------------------
// two_floor_lift_controller_core
// Poll-driven controller for a two-floor lift with request latches.
// ----------------------------------------------------------------------------
// Each request on the input channel is one poll of six active-low buttons and
// sensors. The poll is latched into sticky request bits and the six-phase
// machine (door closed, door open, waiting for arrival, at either floor) is
// stepped in the same clock, so one poll is taken every cycle while in_ready
// is high; its result (drive bits, phase code, motor-running flag) is then
// registered. The only work path is the combinational step logic between the
// state registers and the result register; a two-entry output buffer lets a
// poll be accepted while an earlier result still waits, and in_ready drops
// only when both entries are full. After a departure the motor runs for
// travel_polls polls, during which polls are consumed but not latched.
// open_polls sets how many polls the door stays open. Reset puts the lift
// closed at floor 0 with the arrived-at-0 latch set and both registers at 50.
// Write configuration only while no poll is in flight.
// ----------------------------------------------------------------------------
module two_floor_lift_controller_core
  import lftc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // poll requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IO_W-1:0]    raw_inputs,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IO_W-1:0]    drive_bits,
  output logic [2:0]         state_code,
  output logic               moving,
  // configuration
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [TIMER_W-1:0] cfg_data
);

  logic [TIMER_W-1:0] open_polls;
  logic [TIMER_W-1:0] travel_polls;
  lift_state_t        state;
  lift_state_t        state_next;
  lift_result_t       step_result;
  lift_result_t       out_res;
  lift_result_t       skid_res;
  logic               skid_valid;
  logic               in_accept;
  logic               out_free;

  assign in_ready  = ~skid_valid;
  assign in_accept = in_valid & in_ready;
  // the output register can take a new result this cycle
  assign out_free  = ~out_valid | out_ready;

  lftc_step u_step (
    .cur          (state),
    .raw_inputs   (raw_inputs),
    .open_polls   (open_polls),
    .travel_polls (travel_polls),
    .nxt          (state_next),
    .result       (step_result)
  );

  // Configuration registers: plain write, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      open_polls   <= OPEN_RESET;
      travel_polls <= TRAVEL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_OPEN_POLLS:   open_polls   <= cfg_data;
        CFG_TRAVEL_POLLS: travel_polls <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Controller state: advance once per accepted poll
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_CLOSED0;
      state.latches      <= LATCH_RESET;
      state.door_timer   <= '0;
      state.travel_timer <= '0;
      state.drive        <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Output register plus skid entry. The skid entry fills only when a result
  // arrives while the output register is held; it drains before new polls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid  <= in_accept;
        end
      end else if (in_accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) out_res <= skid_res;
      else if (in_accept) out_res <= step_result;
    end
    if (in_accept && !out_free) skid_res <= step_result;
  end

  assign drive_bits = out_res.drive_bits;
  assign state_code = out_res.state_code;
  assign moving     = out_res.moving;

`ifndef SYNTHESIS
  // skid entry is only ever occupied behind a held result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full with output register empty");

  // a travel countdown only runs while waiting for arrival
  a_travel_in_wait : assert property (@(posedge clk) disable iff (rst)
    (state.travel_timer != '0) |-> (state.phase == PH_WAIT0 || state.phase == PH_WAIT1))
    else $error("travel countdown outside a wait phase");

  // door open and door close coils are never driven together
  a_door_coils : assert property (@(posedge clk) disable iff (rst)
    !(state.drive[D_DOPEN] && state.drive[D_DCLOSE]))
    else $error("door open and close driven together");

  // a poll taken during the countdown leaves the latches untouched
  a_latch_hold : assert property (@(posedge clk) disable iff (rst)
    (in_accept && state.travel_timer != '0) |=> $stable(state.latches))
    else $error("request latches changed during motor run");
`endif

endmodule

@@ hdl/lftc_step.sv @@
// ----------------------------------------------------------------------------
// lftc_step
// Next-state logic for one poll: latch requests, step the phase machine.
// ----------------------------------------------------------------------------
module lftc_step
  import lftc_pkg::*;
(
  input  lift_state_t        cur,
  input  logic [IO_W-1:0]    raw_inputs,
  input  logic [TIMER_W-1:0] open_polls,
  input  logic [TIMER_W-1:0] travel_polls,
  output lift_state_t        nxt,
  output lift_result_t       result
);

  // lamp for the floor, motor off
  function automatic logic [IO_W-1:0] at_floor(input logic [IO_W-1:0] d, input logic upper);
    logic [IO_W-1:0] r;
    r = d;
    r[D_LAMP0] = ~upper;
    r[D_LAMP1] = upper;
    r[D_UP]    = 1'b0;
    r[D_DOWN]  = 1'b0;
    return r;
  endfunction

  function automatic logic [IO_W-1:0] door_shut(input logic [IO_W-1:0] d);
    logic [IO_W-1:0] r;
    r = d;
    r[D_DOPEN]  = 1'b0;
    r[D_DCLOSE] = 1'b1;
    return r;
  endfunction

  function automatic logic [IO_W-1:0] door_release(input logic [IO_W-1:0] d);
    logic [IO_W-1:0] r;
    r = d;
    r[D_DOPEN]  = 1'b1;
    r[D_DCLOSE] = 1'b0;
    return r;
  endfunction

  // motor on in one direction, lamps off, door shut
  function automatic logic [IO_W-1:0] depart_drive(input logic [IO_W-1:0] d,
                                                   input logic going_up);
    logic [IO_W-1:0] r;
    r = door_shut(d);
    r[D_LAMP0] = 1'b0;
    r[D_LAMP1] = 1'b0;
    r[D_UP]    = going_up;
    r[D_DOWN]  = ~going_up;
    return r;
  endfunction

  logic [IO_W-1:0]    lat;
  logic [TIMER_W-1:0] dt_inc;
  logic               upper;

  always_comb begin
    nxt    = cur;
    lat    = cur.latches | ~raw_inputs;
    dt_inc = (cur.door_timer != TIMER_MAX) ? cur.door_timer + TIMER_W'(1) : cur.door_timer;
    upper  = (cur.phase == PH_WAIT1) || (cur.phase == PH_OPEN1);

    if (cur.travel_timer != '0) begin
      // motor running: ignore the poll, count down
      nxt.travel_timer = cur.travel_timer - TIMER_W'(1);
    end else begin
      unique case (cur.phase)
        PH_CLOSED1: begin
          nxt.door_timer = '0;
          lat[B_CLOSE]   = 1'b0;
          nxt.drive      = door_shut(at_floor(cur.drive, 1'b1));
          if (lat[B_OPEN]) nxt.phase = PH_OPEN1;
          if (lat[B_CALL1]) begin
            nxt.phase    = PH_OPEN1;
            lat[B_CALL1] = 1'b0;
          end
          if (lat[B_CALL0]) begin
            nxt.drive        = depart_drive(nxt.drive, 1'b0);
            nxt.travel_timer = travel_polls;
            lat[B_OK0]       = 1'b0;
            lat[B_OK1]       = 1'b0;
            lat[B_CALL0]     = 1'b0;
            nxt.phase        = PH_WAIT0;
          end
        end
        PH_OPEN0, PH_OPEN1: begin
          lat[B_OPEN]    = 1'b0;
          nxt.drive      = door_release(at_floor(cur.drive, upper));
          nxt.door_timer = dt_inc;
          if (lat[B_CLOSE] || (dt_inc >= open_polls))
            nxt.phase = upper ? PH_CLOSED1 : PH_CLOSED0;
        end
        PH_WAIT0, PH_WAIT1: begin
          lat[B_OPEN]  = 1'b0;
          lat[B_CLOSE] = 1'b0;
          nxt.drive    = door_shut(at_floor(cur.drive, upper));
          if (upper ? lat[B_OK1] : lat[B_OK0])
            nxt.phase = upper ? PH_CLOSED1 : PH_CLOSED0;
        end
        default: begin
          // closed at floor 0, and any unused code
          nxt.phase      = PH_CLOSED0;
          nxt.door_timer = '0;
          lat[B_CLOSE]   = 1'b0;
          nxt.drive      = door_shut(at_floor(cur.drive, 1'b0));
          if (lat[B_OPEN]) nxt.phase = PH_OPEN0;
          lat[B_CALL0] = 1'b0;
          if (lat[B_CALL1]) begin
            nxt.drive        = depart_drive(nxt.drive, 1'b1);
            nxt.travel_timer = travel_polls;
            lat[B_OK0]       = 1'b0;
            lat[B_OK1]       = 1'b0;
            lat[B_CALL1]     = 1'b0;
            nxt.phase        = PH_WAIT1;
          end
        end
      endcase
      nxt.latches = lat;
    end

    result.drive_bits = nxt.drive;
    result.state_code = 3'(nxt.phase);
    result.moving     = (cur.travel_timer != '0) || (nxt.travel_timer != '0);
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-floor lift controller core.
// ----------------------------------------------------------------------------
// Polls go in through the request channel and every accepted poll is run
// through a local model of the lift: latches, phase, door and travel timers,
// held drive bits. Its outcome is queued, and each result leaving the core is
// checked against the head of that queue. The run walks the reset settings, a
// directed tour of every phase, a full-scale door timer and a long run,
// random traffic under several timer settings and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import lftc_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES = 64;    // long receiver hold-off
  localparam logic [IO_W-1:0] IDLE_POLL = '1;  // nothing pressed (active low)

  logic               clk;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [IO_W-1:0]    raw_inputs = '1;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [IO_W-1:0]    drive_bits;
  logic [2:0]         state_code;
  logic               moving;
  logic               cfg_write  = 1'b0;
  logic               cfg_index  = CFG_OPEN_POLLS;
  logic [TIMER_W-1:0] cfg_data   = '0;

  // Lift model state, mirrors the core's registers
  phase_t             lift_phase;
  logic [IO_W-1:0]    req_latch;
  logic [TIMER_W-1:0] door_cnt;
  logic [TIMER_W-1:0] travel_cnt;
  logic [IO_W-1:0]    drive_hold;
  logic [TIMER_W-1:0] open_limit;
  logic [TIMER_W-1:0] travel_len;

  lift_result_t expected_q[$];
  lift_result_t head_exp;
  int           fault_count  = 0;
  int           result_count = 0;
  int           quiet_cycles = 0;

  // Idling control shared by the sender, the receiver and the test tasks
  bit steady      = 1'b0;
  int hold_asked  = 0;
  int hold_taken  = 0;
  int hold_left   = 0;
  int stall_left  = 0;

  two_floor_lift_controller_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .raw_inputs (raw_inputs),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive_bits (drive_bits),
    .state_code (state_code),
    .moving     (moving),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Lift model
  // --------------------------------------------------------------------------

  // Light the lamp of the floor and stop the motor
  function automatic void show_floor(logic upper);
    drive_hold[D_LAMP0] = ~upper;
    drive_hold[D_LAMP1] = upper;
    drive_hold[D_UP]    = 1'b0;
    drive_hold[D_DOWN]  = 1'b0;
  endfunction

  function automatic void shut_door();
    drive_hold[D_DOPEN]  = 1'b0;
    drive_hold[D_DCLOSE] = 1'b1;
  endfunction

  // Departure: door shut, motor on, arrival latches dropped, countdown loaded
  function automatic void start_run(logic going_up);
    drive_hold[D_LAMP0] = 1'b0;
    drive_hold[D_LAMP1] = 1'b0;
    shut_door();
    drive_hold[D_UP]    = going_up;
    drive_hold[D_DOWN]  = ~going_up;
    travel_cnt          = travel_len;
    req_latch[B_OK0]    = 1'b0;
    req_latch[B_OK1]    = 1'b0;
  endfunction

  // One poll with the door open: count, close on request or on time-out
  function automatic void door_step(phase_t shut_phase, logic upper);
    req_latch[B_OPEN] = 1'b0;
    show_floor(upper);
    drive_hold[D_DCLOSE] = 1'b0;
    drive_hold[D_DOPEN]  = 1'b1;
    if (door_cnt != TIMER_MAX) door_cnt++;
    if (req_latch[B_CLOSE]) lift_phase = shut_phase;
    if (door_cnt >= open_limit) lift_phase = shut_phase;
  endfunction

  function automatic lift_result_t predict_poll(logic [IO_W-1:0] raw);
    logic         motor_on;
    logic         upper;
    lift_result_t res;
    motor_on = 1'b0;
    if (travel_cnt != '0) begin
      // motor running: the poll is swallowed, outputs held
      travel_cnt--;
      motor_on = 1'b1;
    end else begin
      req_latch |= ~raw;
      case (lift_phase)
        PH_CLOSED1: begin
          door_cnt = '0;
          req_latch[B_CLOSE] = 1'b0;
          show_floor(1'b1);
          shut_door();
          if (req_latch[B_OPEN]) lift_phase = PH_OPEN1;
          if (req_latch[B_CALL1]) begin
            lift_phase = PH_OPEN1;
            req_latch[B_CALL1] = 1'b0;
          end
          if (req_latch[B_CALL0]) begin
            start_run(1'b0);
            lift_phase = PH_WAIT0;
            req_latch[B_CALL0] = 1'b0;
          end
        end
        PH_OPEN0: door_step(PH_CLOSED0, 1'b0);
        PH_OPEN1: door_step(PH_CLOSED1, 1'b1);
        PH_WAIT0, PH_WAIT1: begin
          upper = (lift_phase == PH_WAIT1);
          req_latch[B_OPEN]  = 1'b0;
          req_latch[B_CLOSE] = 1'b0;
          show_floor(upper);
          shut_door();
          if (req_latch[upper ? B_OK1 : B_OK0])
            lift_phase = upper ? PH_CLOSED1 : PH_CLOSED0;
        end
        default: begin
          // closed at floor 0; a floor-0 call here only drops the latch
          lift_phase = PH_CLOSED0;
          door_cnt = '0;
          req_latch[B_CLOSE] = 1'b0;
          show_floor(1'b0);
          shut_door();
          if (req_latch[B_OPEN]) lift_phase = PH_OPEN0;
          req_latch[B_CALL0] = 1'b0;
          if (req_latch[B_CALL1]) begin
            start_run(1'b1);
            lift_phase = PH_WAIT1;
            req_latch[B_CALL1] = 1'b0;
          end
        end
      endcase
      if (travel_cnt != '0) motor_on = 1'b1;
    end
    res.drive_bits = drive_hold;
    res.state_code = lift_phase;
    res.moving     = motor_on;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a short gap, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Poll with a single button or sensor pressed
  function automatic logic [IO_W-1:0] press_only(int unsigned pos);
    return ~(IO_W'(1) << pos);
  endfunction

  // Sparse presses most of the time so the lift gets round its phases
  function automatic logic [IO_W-1:0] rand_poll();
    int              roll;
    logic [IO_W-1:0] raw;
    roll = $urandom_range(0, 99);
    if (roll < 20) return IDLE_POLL;
    if (roll < 30) return IO_W'($urandom_range(0, 63));
    raw = IDLE_POLL;
    for (int b = 0; b < IO_W; b++)
      if ($urandom_range(0, 99) < 12) raw[b] = 1'b0;
    return raw;
  endfunction

  // Offer one poll, hold it until taken, then queue its expected result.
  // Valid is only dropped for a real gap, so it never falls and rises in one step.
  task automatic send_poll(input logic [IO_W-1:0] raw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_inputs <= raw;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_poll(raw));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Write both timer registers; only called with the core idle
  task automatic set_timers(input logic [TIMER_W-1:0] open_val,
                            input logic [TIMER_W-1:0] travel_val);
    cfg_write <= 1'b1;
    cfg_index <= CFG_OPEN_POLLS;
    cfg_data  <= open_val;
    @(posedge clk);
    cfg_index <= CFG_TRAVEL_POLLS;
    cfg_data  <= travel_val;
    @(posedge clk);
    cfg_write  <= 1'b0;
    open_limit = open_val;
    travel_len = travel_val;
  endtask

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("%s", what);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: door opens at floor 0 and stays open past a few polls
  task automatic test_reset_state();
    send_poll(IDLE_POLL);
    send_poll(press_only(B_OPEN));
    repeat (4) send_poll(IDLE_POLL);
    send_poll(press_only(B_CLOSE));
    send_poll(IDLE_POLL);
  endtask

  // Walk every phase with short timers, including the odd corners
  task automatic test_directed_walk();
    drain_results();
    set_timers(TIMER_W'(3), TIMER_W'(2));
    send_poll(IDLE_POLL);
    send_poll(press_only(B_CALL0));     // own floor call at floor 0: door stays shut
    send_poll(press_only(B_OPEN));
    send_poll(IDLE_POLL);
    send_poll(press_only(B_CLOSE));
    send_poll('0);                      // everything at once: leave for floor 1
    send_poll('0);                      // swallowed while travelling
    send_poll('0);
    send_poll(press_only(B_OPEN) & press_only(B_CLOSE));  // dropped while waiting
    send_poll(press_only(B_OK1));
    send_poll(IDLE_POLL);
    send_poll(press_only(B_CALL1));     // own floor call at floor 1: door opens
    repeat (3) send_poll(IDLE_POLL);    // door times out
    send_poll(press_only(B_OPEN));
    send_poll(press_only(B_CLOSE));
    send_poll(press_only(B_CALL0));
    send_poll(IDLE_POLL);
    send_poll(IDLE_POLL);
    send_poll(press_only(B_OK0));
    send_poll(IDLE_POLL);
  endtask

  // Door timer at full scale, closed early by request, then a long run
  task automatic test_extreme_timers();
    drain_results();
    set_timers(TIMER_MAX, TIMER_W'(100));
    steady = 1'b1;
    send_poll(press_only(B_OPEN));
    repeat (8) send_poll(IDLE_POLL);
    send_poll(press_only(B_CLOSE));
    steady = 1'b0;
    send_poll(press_only(lift_phase == PH_CLOSED0 ? B_CALL1 : B_CALL0));
    while (travel_cnt != '0) send_poll(rand_poll());
    send_poll('0);
    drain_results();
    // shortest door, no travel countdown
    set_timers(TIMER_W'(1), '0);
    repeat (12) send_poll(rand_poll());
  endtask

  task automatic test_random_traffic(input int polls,
                                     input logic [TIMER_W-1:0] open_val,
                                     input logic [TIMER_W-1:0] travel_val);
    drain_results();
    set_timers(open_val, travel_val);
    for (int i = 0; i < polls; i++) begin
      steady = ((i % 60) >= 45);  // a burst with no idling on either side
      send_poll(rand_poll());
    end
    steady = 1'b0;
  endtask

  // Hold the receiver off long enough for the core to fill and stall requests
  task automatic test_backpressure();
    steady = 1'b1;
    hold_asked++;
    repeat (40) send_poll(rand_poll());
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off when asked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 20) begin
      stall_left <= pick_gap();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (expected_q.size() == 0) begin
        report_fault($sformatf("result %0d: unexpected, drive %b state %0d moving %b",
                               result_count, drive_bits, state_code, moving));
      end else begin
        head_exp = expected_q.pop_front();
        if (drive_bits !== head_exp.drive_bits || state_code !== head_exp.state_code ||
            moving !== head_exp.moving)
          report_fault($sformatf(
            "result %0d: drive %b exp %b, state %0d exp %0d, moving %b exp %b",
            result_count, drive_bits, head_exp.drive_bits, state_code,
            head_exp.state_code, moving, head_exp.moving));
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("** two_floor_lift_controller_core: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // model starts where reset leaves the core
    lift_phase = PH_CLOSED0;
    req_latch  = LATCH_RESET;
    door_cnt   = '0;
    travel_cnt = '0;
    drive_hold = '0;
    open_limit = OPEN_RESET;
    travel_len = TRAVEL_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_walk();
    test_extreme_timers();
    test_random_traffic(80, TIMER_W'(1), '0);
    test_random_traffic(90, TIMER_W'($urandom_range(2, 12)),
                        TIMER_W'($urandom_range(1, 8)));
    test_random_traffic(80, TIMER_W'(5), TIMER_W'(3));
    test_backpressure();

    drain_results();
    repeat (5) @(posedge clk);
    if (expected_q.size() != 0)
      report_fault($sformatf("%0d results never arrived", expected_q.size()));
    if (fault_count == 0) begin
      $display("** two_floor_lift_controller_core: PASSED **");
    end else begin
      $display("** two_floor_lift_controller_core: FAILED **");
    end
    $finish;
  end

endmodule
